// ===== rtl/core/heightmap_triangle_height_query_macros.svh =====
// Assertion macros shared by the height query RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_MACROS_SVH

`ifndef SYNTHESIS
`define HTHQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HTHQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  `HTHQ_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)
`define HTHQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `HTHQ_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)
`else
`define HTHQ_ASSERT(lbl, clk, rstn, prop, msg)
`define HTHQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define HTHQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/core/hthq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the heightmap height query pipeline.
// No dependencies.
package hthq_pkg;

  localparam int unsigned INDEX_W  = 14;
  localparam int unsigned HEIGHT_W = 24;
  localparam int unsigned COORD_W  = 15;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned CELL_W   = COORD_W - FRAC_W;
  localparam int unsigned TDATA_W  = 72;
  localparam int unsigned STORE_DEPTH = 1 << INDEX_W;

  localparam logic signed [HEIGHT_W-1:0] LIFT_RESET = 24'sd256;
  localparam logic signed [HEIGHT_W-1:0] H_MAX      = 24'sh7FFFFF;
  localparam logic signed [HEIGHT_W-1:0] H_MIN      = 24'sh800000;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } hthq_kind_e;

  typedef struct packed {
    hthq_kind_e                 kind;
    logic [INDEX_W-1:0]         index;
    logic signed [HEIGHT_W-1:0] height;
    logic [COORD_W-1:0]         x;
    logic [COORD_W-1:0]         z;
  } hthq_item_t;

  typedef struct packed {
    hthq_kind_e kind;
    logic       oor;
  } hthq_ctl_t;

endpackage

// ===== rtl/core/hthq_cell_locate.sv =====
`timescale 1ns / 1ps
// Four-stage front end: cell, offsets, triangle weights and vertex addresses.
// Depends on hthq_pkg and the assertion macro header.
`include "heightmap_triangle_height_query_macros.svh"
module hthq_cell_locate #(
  parameter int unsigned GRID_WIDTH = 128,
  parameter int unsigned GRID_DEPTH = 128,
  parameter int unsigned CELL_SIZE  = 1,
  parameter int unsigned WGT_W      = 9
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  hthq_pkg::hthq_item_t             in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output hthq_pkg::hthq_ctl_t              out_ctl_o,
  output logic [hthq_pkg::INDEX_W-1:0]     out_addr_a_o,
  output logic [hthq_pkg::INDEX_W-1:0]     out_addr_b_o,
  output logic [hthq_pkg::INDEX_W-1:0]     out_addr_c_o,
  output logic signed [hthq_pkg::HEIGHT_W-1:0] out_height_o,
  output logic [WGT_W-1:0]                 out_wgt_a_o,
  output logic [WGT_W-1:0]                 out_wgt_b_o
);
  import hthq_pkg::*;

  localparam int unsigned S        = CELL_SIZE * 256;
  localparam int unsigned RECIP_SH = 16;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam int unsigned PROD_W   = CELL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SH) + CELL_SIZE - 1) / CELL_SIZE);
  localparam int unsigned COLC_W   = CELL_W + $clog2(CELL_SIZE + 1);
  localparam int unsigned XR_W     = COLC_W + FRAC_W;
  localparam logic [WGT_W-1:0] S_W = WGT_W'(S);

  logic [3:0] v_q;
  logic [3:0] rdy;

  hthq_item_t                 item1_q;
  hthq_kind_e                 kind2_q;
  logic [INDEX_W-1:0]         index2_q;
  logic signed [HEIGHT_W-1:0] height2_q;
  logic [COORD_W-1:0]         x2_q, z2_q;
  logic [CELL_W-1:0]          col2_q, row2_q;
  hthq_ctl_t                  ctl3_q;
  logic [INDEX_W-1:0]         index3_q;
  logic signed [HEIGHT_W-1:0] height3_q;
  logic [INDEX_W-1:0]         rowmul3_q;
  logic [CELL_W-1:0]          col3_q;
  logic                       upper3_q;
  logic [WGT_W-1:0]           wa3_q, wb3_q;
  hthq_ctl_t                  ctl4_q;
  logic [INDEX_W-1:0]         addr_a4_q, addr_b4_q, addr_c4_q;
  logic signed [HEIGHT_W-1:0] height4_q;
  logic [WGT_W-1:0]           wa4_q, wb4_q;

  logic [PROD_W-1:0]  prod_x, prod_z;
  logic [COLC_W-1:0]  colx, rowz;
  logic [XR_W-1:0]    rx_full, rz_full;
  logic [WGT_W-1:0]   rx, rz;
  logic               upper_d, oor_d;
  logic [INDEX_W-1:0] base, a10, a01, a11, addr_c_d;

  always_comb begin
    rdy[3] = !v_q[3] || out_ready_i;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // cell column and row by reciprocal multiply
  assign prod_x = PROD_W'(item1_q.x[COORD_W-1:FRAC_W]) * PROD_W'(RECIP);
  assign prod_z = PROD_W'(item1_q.z[COORD_W-1:FRAC_W]) * PROD_W'(RECIP);

  // offsets inside the cell and triangle choice
  assign colx    = COLC_W'(col2_q) * COLC_W'(CELL_SIZE);
  assign rowz    = COLC_W'(row2_q) * COLC_W'(CELL_SIZE);
  assign rx_full = XR_W'(x2_q) - {colx, FRAC_W'(0)};
  assign rz_full = XR_W'(z2_q) - {rowz, FRAC_W'(0)};
  assign rx      = rx_full[WGT_W-1:0];
  assign rz      = rz_full[WGT_W-1:0];
  assign upper_d = ((WGT_W+1)'(rx) + (WGT_W+1)'(rz)) > (WGT_W+1)'(S);
  assign oor_d   = (kind2_q == KIND_QUERY) &&
                   ((int'(col2_q) >= int'(GRID_WIDTH) - 1) ||
                    (int'(row2_q) >= int'(GRID_DEPTH) - 1));

  // vertex addresses, wrapping over the store
  assign base = rowmul3_q + INDEX_W'(col3_q);
  assign a10  = base + INDEX_W'(1);
  assign a01  = base + INDEX_W'(GRID_WIDTH);
  assign a11  = base + INDEX_W'(GRID_WIDTH + 1);
  assign addr_c_d = (ctl3_q.kind == KIND_WRITE) ? index3_q : (upper3_q ? a11 : base);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      item1_q <= in_item_i;
    end
    if (rdy[1]) begin
      kind2_q   <= item1_q.kind;
      index2_q  <= item1_q.index;
      height2_q <= item1_q.height;
      x2_q      <= item1_q.x;
      z2_q      <= item1_q.z;
      col2_q    <= prod_x[RECIP_SH +: CELL_W];
      row2_q    <= prod_z[RECIP_SH +: CELL_W];
    end
    if (rdy[2]) begin
      ctl3_q.kind <= kind2_q;
      ctl3_q.oor  <= oor_d;
      index3_q    <= index2_q;
      height3_q   <= height2_q;
      rowmul3_q   <= INDEX_W'(row2_q) * INDEX_W'(GRID_WIDTH);
      col3_q      <= col2_q;
      upper3_q    <= upper_d;
      wa3_q       <= upper_d ? S_W - rz : rx;
      wb3_q       <= upper_d ? S_W - rx : rz;
    end
    if (rdy[3]) begin
      ctl4_q    <= ctl3_q;
      addr_a4_q <= a10;
      addr_b4_q <= a01;
      addr_c4_q <= addr_c_d;
      height4_q <= height3_q;
      wa4_q     <= wa3_q;
      wb4_q     <= wb3_q;
    end
  end

  assign out_valid_o  = v_q[3];
  assign out_ctl_o    = ctl4_q;
  assign out_addr_a_o = addr_a4_q;
  assign out_addr_b_o = addr_b4_q;
  assign out_addr_c_o = addr_c4_q;
  assign out_height_o = height4_q;
  assign out_wgt_a_o  = wa4_q;
  assign out_wgt_b_o  = wb4_q;

  `HTHQ_ASSERT_IMPL(a_wgt_sum, clk_i, rst_ni, v_q[2], ((WGT_W+1)'(wa3_q) + (WGT_W+1)'(wb3_q)) <= (WGT_W+1)'(S), "triangle weights exceed cell size")
  `HTHQ_ASSERT_IMPL(a_upper_wgt, clk_i, rst_ni, v_q[2] && upper3_q, ((WGT_W+1)'(wa3_q) + (WGT_W+1)'(wb3_q)) < (WGT_W+1)'(S), "upper triangle weights out of range")
  `HTHQ_ASSERT_IMPL(a_row_step, clk_i, rst_ni, v_q[3] && out_ctl_o.kind == KIND_QUERY, (addr_b4_q - addr_a4_q) == INDEX_W'(GRID_WIDTH - 1), "vertex addresses not one row apart")

endmodule

// ===== rtl/core/hthq_height_store.sv =====
`timescale 1ns / 1ps
// Vertex height store: two copies of the grid, three registered reads per item.
// Depends on hthq_pkg.
module hthq_height_store #(
  parameter int unsigned WGT_W = 9
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  hthq_pkg::hthq_ctl_t                  in_ctl_i,
  input  logic [hthq_pkg::INDEX_W-1:0]         in_addr_a_i,
  input  logic [hthq_pkg::INDEX_W-1:0]         in_addr_b_i,
  input  logic [hthq_pkg::INDEX_W-1:0]         in_addr_c_i,
  input  logic signed [hthq_pkg::HEIGHT_W-1:0] in_height_i,
  input  logic [WGT_W-1:0]                     in_wgt_a_i,
  input  logic [WGT_W-1:0]                     in_wgt_b_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output hthq_pkg::hthq_ctl_t                  out_ctl_o,
  output logic signed [hthq_pkg::HEIGHT_W-1:0] out_h_a_o,
  output logic signed [hthq_pkg::HEIGHT_W-1:0] out_h_b_o,
  output logic signed [hthq_pkg::HEIGHT_W-1:0] out_h_c_o,
  output logic [WGT_W-1:0]                     out_wgt_a_o,
  output logic [WGT_W-1:0]                     out_wgt_b_o
);
  import hthq_pkg::*;

  logic signed [HEIGHT_W-1:0] mem_a [STORE_DEPTH];
  logic signed [HEIGHT_W-1:0] mem_b [STORE_DEPTH];

  logic                       v_q;
  logic                       ld;
  hthq_ctl_t                  ctl_q;
  logic signed [HEIGHT_W-1:0] h_a_q, h_b_q, h_c_q;
  logic [WGT_W-1:0]           wa_q, wb_q;

  assign in_ready_o = !v_q || out_ready_i;
  assign ld         = in_ready_o && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  // writes land here, in item order with the reads
  always_ff @(posedge clk_i) begin
    if (ld && in_ctl_i.kind == KIND_WRITE) begin
      mem_a[in_addr_c_i] <= in_height_i;
      mem_b[in_addr_c_i] <= in_height_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      h_a_q <= mem_a[in_addr_a_i];
      h_b_q <= mem_a[in_addr_b_i];
      h_c_q <= mem_b[in_addr_c_i];
      ctl_q <= in_ctl_i;
      wa_q  <= in_wgt_a_i;
      wb_q  <= in_wgt_b_i;
    end
  end

  assign out_valid_o = v_q;
  assign out_ctl_o   = ctl_q;
  assign out_h_a_o   = h_a_q;
  assign out_h_b_o   = h_b_q;
  assign out_h_c_o   = h_c_q;
  assign out_wgt_a_o = wa_q;
  assign out_wgt_b_o = wb_q;

endmodule

// ===== rtl/core/hthq_plane_interp.sv =====
`timescale 1ns / 1ps
// Six-stage back end: plane interpolation, rounding divide by cell size, lift, clamp.
// Depends on hthq_pkg and the assertion macro header.
`include "heightmap_triangle_height_query_macros.svh"
module hthq_plane_interp #(
  parameter int unsigned CELL_SIZE = 1,
  parameter int unsigned WGT_W     = 9
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  hthq_pkg::hthq_ctl_t                  in_ctl_i,
  input  logic signed [hthq_pkg::HEIGHT_W-1:0] in_h_a_i,
  input  logic signed [hthq_pkg::HEIGHT_W-1:0] in_h_b_i,
  input  logic signed [hthq_pkg::HEIGHT_W-1:0] in_h_c_i,
  input  logic [WGT_W-1:0]                     in_wgt_a_i,
  input  logic [WGT_W-1:0]                     in_wgt_b_i,
  input  logic signed [hthq_pkg::HEIGHT_W-1:0] lift_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [hthq_pkg::HEIGHT_W-1:0] out_height_o,
  output logic                                 out_oor_o
);
  import hthq_pkg::*;

  localparam int unsigned NSTG  = 6;
  localparam int unsigned S     = CELL_SIZE * 256;
  localparam int unsigned NUM_W = HEIGHT_W + WGT_W + 3;
  localparam int unsigned DIF_W = HEIGHT_W + 1;
  localparam int unsigned LC    = $clog2(CELL_SIZE);
  localparam int unsigned UW    = HEIGHT_W + LC;
  localparam int unsigned K2    = HEIGHT_W + 2 * LC;
  localparam int unsigned M_W   = K2 + 1;
  localparam int unsigned SPLIT = 14;
  localparam int unsigned PL_W  = SPLIT + M_W;
  localparam int unsigned PH_W  = UW - SPLIT + M_W;
  localparam int unsigned FULL_W = UW + M_W;
  localparam logic signed [NUM_W-1:0] S_NUM = NUM_W'(S);
  localparam logic signed [NUM_W-1:0] ROUND_K =
    NUM_W'((64'(S) << (HEIGHT_W - 1)) + 64'(S / 2));
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << K2) + 64'(CELL_SIZE) - 1) / 64'(CELL_SIZE));

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] rdy;
  hthq_ctl_t       ctl_q [NSTG-1];

  logic signed [DIF_W-1:0]    da0_q, db0_q;
  logic signed [NUM_W-1:0]    hcs0_q;
  logic [WGT_W-1:0]           wa0_q, wb0_q;
  logic signed [NUM_W-1:0]    pa1_q, pb1_q, hcs1_q;
  logic [UW-1:0]              u2_q;
  logic [PL_W-1:0]            pl3_q;
  logic [PH_W-1:0]            ph3_q;
  logic signed [HEIGHT_W-1:0] y4_q;
  logic signed [HEIGHT_W-1:0] height5_q;
  logic                       oor5_q;

  logic signed [NUM_W-1:0]    tot;
  logic [FULL_W-1:0]          full;
  logic [HEIGHT_W-1:0]        quot;
  logic signed [HEIGHT_W:0]   ysum;
  logic signed [HEIGHT_W-1:0] ysat;
  logic                       ld5;

  always_comb begin
    rdy[NSTG-1] = !v_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];
  assign ld5        = rdy[NSTG-1] && v_q[NSTG-2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // weighted sum plus half a cell, biased so that the value stays positive
  assign tot  = pa1_q + pb1_q + hcs1_q + ROUND_K;
  assign full = FULL_W'(pl3_q) + (FULL_W'(ph3_q) << SPLIT);
  assign quot = full[K2 +: HEIGHT_W];

  assign ysum = DIF_W'(y4_q) + DIF_W'(lift_i);
  always_comb begin
    if (ysum[HEIGHT_W] != ysum[HEIGHT_W-1]) begin
      ysat = ysum[HEIGHT_W] ? H_MIN : H_MAX;
    end else begin
      ysat = ysum[HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ctl_q[0] <= in_ctl_i;
      da0_q    <= DIF_W'(in_h_a_i) - DIF_W'(in_h_c_i);
      db0_q    <= DIF_W'(in_h_b_i) - DIF_W'(in_h_c_i);
      hcs0_q   <= NUM_W'(in_h_c_i) * S_NUM;
      wa0_q    <= in_wgt_a_i;
      wb0_q    <= in_wgt_b_i;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (rdy[k]) ctl_q[k] <= ctl_q[k-1];
    end
    if (rdy[1]) begin
      pa1_q  <= NUM_W'(da0_q) * $signed(NUM_W'(wa0_q));
      pb1_q  <= NUM_W'(db0_q) * $signed(NUM_W'(wb0_q));
      hcs1_q <= hcs0_q;
    end
    if (rdy[2]) begin
      u2_q <= tot[FRAC_W +: UW];
    end
    if (rdy[3]) begin
      pl3_q <= PL_W'(u2_q[SPLIT-1:0]) * PL_W'(RECIP);
      ph3_q <= PH_W'(u2_q[UW-1:SPLIT]) * PH_W'(RECIP);
    end
    if (rdy[4]) begin
      // remove the bias of 2^23
      y4_q <= {~quot[HEIGHT_W-1], quot[HEIGHT_W-2:0]};
    end
    if (rdy[5]) begin
      height5_q <= (ctl_q[4].kind == KIND_QUERY && !ctl_q[4].oor) ? ysat : '0;
      oor5_q    <= (ctl_q[4].kind == KIND_QUERY) && ctl_q[4].oor;
    end
  end

  assign out_valid_o  = v_q[NSTG-1];
  assign out_height_o = height5_q;
  assign out_oor_o    = oor5_q;

  `HTHQ_ASSERT_NEXT(a_sat_pos, clk_i, rst_ni, ld5 && ctl_q[4].kind == KIND_QUERY && !ctl_q[4].oor && !y4_q[HEIGHT_W-1] && !lift_i[HEIGHT_W-1], !out_height_o[HEIGHT_W-1], "positive sum wrapped negative")
  `HTHQ_ASSERT_NEXT(a_sat_neg, clk_i, rst_ni, ld5 && ctl_q[4].kind == KIND_QUERY && !ctl_q[4].oor && y4_q[HEIGHT_W-1] && lift_i[HEIGHT_W-1], out_height_o[HEIGHT_W-1], "negative sum wrapped positive")
  `HTHQ_ASSERT_NEXT(a_zero_result, clk_i, rst_ni, ld5 && (ctl_q[4].kind == KIND_WRITE || ctl_q[4].oor), out_height_o == '0, "write or out of range item with non-zero height")

endmodule

// ===== rtl/core/heightmap_triangle_height_query.sv =====
`timescale 1ns / 1ps
// Heightmap triangle height query. One item is taken per clock cycle while the
// output is not stalled, and passes through eleven register stages: four stages
// locate the cell and form addresses, one stage reads the store, six stages
// interpolate, divide by the cell size, add the lift and clamp. Back-pressure
// collapses bubbles stage by stage. The store is two copies of 16384 x 24 bit
// heights (three reads and one write per cycle); entries read before being
// written are undefined. No clearing pass runs after reset.
// Depends on hthq_pkg, hthq_cell_locate, hthq_height_store, hthq_plane_interp.
module heightmap_triangle_height_query #(
  parameter int unsigned GRID_WIDTH = 128,
  parameter int unsigned GRID_DEPTH = 128,
  parameter int unsigned CELL_SIZE  = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hthq_pkg::HEIGHT_W-1:0]        cfg_wdata_i,    // height_lift
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // vertex_index, vertex_height, query_x, query_z, zero pad
  input  logic [hthq_pkg::TDATA_W-1:0]         s_axis_tdata_i,
  input  logic [0:0]                           s_axis_tuser_i, // kind
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [hthq_pkg::HEIGHT_W-1:0]        m_axis_tdata_o, // surface_height
  output logic [0:0]                           m_axis_tuser_o  // out_of_range
);
  import hthq_pkg::*;

  localparam int unsigned WGT_W = $clog2(CELL_SIZE * 256 + 1);

  logic signed [HEIGHT_W-1:0] lift_q;
  hthq_item_t                 in_item;

  logic               loc_valid, loc_ready;
  hthq_ctl_t          loc_ctl;
  logic [INDEX_W-1:0] loc_addr_a, loc_addr_b, loc_addr_c;
  logic signed [HEIGHT_W-1:0] loc_height;
  logic [WGT_W-1:0]   loc_wa, loc_wb;

  logic               st_valid, st_ready;
  hthq_ctl_t          st_ctl;
  logic signed [HEIGHT_W-1:0] st_h_a, st_h_b, st_h_c;
  logic [WGT_W-1:0]   st_wa, st_wb;

  logic signed [HEIGHT_W-1:0] res_height;
  logic                       res_oor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lift_q <= LIFT_RESET;
    end else if (cfg_we_i) begin
      lift_q <= cfg_wdata_i;
    end
  end

  assign in_item.kind   = hthq_kind_e'(s_axis_tuser_i[0]);
  assign in_item.index  = s_axis_tdata_i[13:0];
  assign in_item.height = s_axis_tdata_i[37:14];
  assign in_item.x      = s_axis_tdata_i[52:38];
  assign in_item.z      = s_axis_tdata_i[67:53];

  hthq_cell_locate #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_DEPTH (GRID_DEPTH),
    .CELL_SIZE  (CELL_SIZE),
    .WGT_W      (WGT_W)
  ) u_locate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .out_valid_o  (loc_valid),
    .out_ready_i  (loc_ready),
    .out_ctl_o    (loc_ctl),
    .out_addr_a_o (loc_addr_a),
    .out_addr_b_o (loc_addr_b),
    .out_addr_c_o (loc_addr_c),
    .out_height_o (loc_height),
    .out_wgt_a_o  (loc_wa),
    .out_wgt_b_o  (loc_wb)
  );

  hthq_height_store #(
    .WGT_W (WGT_W)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (loc_valid),
    .in_ready_o  (loc_ready),
    .in_ctl_i    (loc_ctl),
    .in_addr_a_i (loc_addr_a),
    .in_addr_b_i (loc_addr_b),
    .in_addr_c_i (loc_addr_c),
    .in_height_i (loc_height),
    .in_wgt_a_i  (loc_wa),
    .in_wgt_b_i  (loc_wb),
    .out_valid_o (st_valid),
    .out_ready_i (st_ready),
    .out_ctl_o   (st_ctl),
    .out_h_a_o   (st_h_a),
    .out_h_b_o   (st_h_b),
    .out_h_c_o   (st_h_c),
    .out_wgt_a_o (st_wa),
    .out_wgt_b_o (st_wb)
  );

  hthq_plane_interp #(
    .CELL_SIZE (CELL_SIZE),
    .WGT_W     (WGT_W)
  ) u_interp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (st_valid),
    .in_ready_o   (st_ready),
    .in_ctl_i     (st_ctl),
    .in_h_a_i     (st_h_a),
    .in_h_b_i     (st_h_b),
    .in_h_c_i     (st_h_c),
    .in_wgt_a_i   (st_wa),
    .in_wgt_b_i   (st_wb),
    .lift_i       (lift_q),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_height_o (res_height),
    .out_oor_o    (res_oor)
  );

  assign m_axis_tdata_o    = res_height;
  assign m_axis_tuser_o[0] = res_oor;

endmodule
